@@ rtl/core/lckc_pkg.sv @@
// lckc_pkg: shared types, constants and cipher functions for the key counter
// no dependencies
package lckc_pkg;

  localparam int NUM_CANDIDATES = 256;
  localparam int CAND_W         = $clog2(NUM_CANDIDATES);
  localparam int COUNT_WIDTH    = 16;
  localparam int BLOCK_W        = 16;
  localparam int BIAS_W         = 16;
  localparam int CFG_W          = 16;

  localparam logic [CFG_W-1:0]   EXP_HALF_RST = 16'd5000;
  localparam logic [BLOCK_W-1:0] MODE1_FIXED  = 16'h0103;
  localparam logic [BLOCK_W-1:0] MODE3_FIXED  = 16'h0100;

  typedef enum logic [1:0] {
    MODE_LR_LOW  = 2'd0,
    MODE_LR_ALL  = 2'd1,
    MODE_FR_HIGH = 2'd2,
    MODE_FR_ALL  = 2'd3
  } attack_mode_e;

  typedef enum logic {
    REG_ATTACK_MODE   = 1'b0,
    REG_EXPECTED_HALF = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [BLOCK_W-1:0] plaintext;
    logic [BLOCK_W-1:0] ciphertext;
    logic               last_pair;
  } in_item_t;

  typedef struct packed {
    logic [CAND_W-1:0] best_candidate;
    logic [BIAS_W-1:0] max_bias;
  } out_item_t;

  typedef struct packed {
    logic               upd;
    logic               shift;
    attack_mode_e       mode;
    logic [BLOCK_W-1:0] base;
    logic               raw_par;
  } cell_ctrl_t;

  typedef struct packed {
    logic idle;
    logic shift;
  } scan_stat_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] r;
    case (x)
      4'h0: r = 4'hE;  4'h1: r = 4'h4;  4'h2: r = 4'hD;  4'h3: r = 4'h1;
      4'h4: r = 4'h2;  4'h5: r = 4'hF;  4'h6: r = 4'hB;  4'h7: r = 4'h8;
      4'h8: r = 4'h3;  4'h9: r = 4'hA;  4'hA: r = 4'h6;  4'hB: r = 4'hC;
      4'hC: r = 4'h5;  4'hD: r = 4'h9;  4'hE: r = 4'h0;  4'hF: r = 4'h7;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] r;
    case (x)
      4'h0: r = 4'hE;  4'h1: r = 4'h3;  4'h2: r = 4'h4;  4'h3: r = 4'h8;
      4'h4: r = 4'h1;  4'h5: r = 4'hC;  4'h6: r = 4'hA;  4'h7: r = 4'hF;
      4'h8: r = 4'h7;  4'h9: r = 4'hD;  4'hA: r = 4'h9;  4'hB: r = 4'h6;
      4'hC: r = 4'hB;  4'hD: r = 4'h2;  4'hE: r = 4'h0;  4'hF: r = 4'h5;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] substitute(input logic [BLOCK_W-1:0] v,
                                                    input logic inv);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = inv ? sbox_inv(v[4*n +: 4]) : sbox_fwd(v[4*n +: 4]);
    end
    return r;
  endfunction

  function automatic logic last_round(input attack_mode_e m);
    return (m == MODE_LR_LOW) || (m == MODE_LR_ALL);
  endfunction

  function automatic logic [BLOCK_W-1:0] key_mask(input attack_mode_e m,
                                                  input logic [CAND_W-1:0] j);
    logic [BLOCK_W-1:0] r;
    case (m)
      MODE_LR_LOW:  r = {4'h0, j[7:4], 4'h0, j[3:0]};
      MODE_LR_ALL:  r = {j[7:4], 4'h0, j[3:0], 4'h0} | MODE1_FIXED;
      // high nibble of the candidate is not used in this mode
      MODE_FR_HIGH: r = {4'h0, j[3:0], 8'h00};
      MODE_FR_ALL:  r = {8'h00, j} | MODE3_FIXED;
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] u_mask(input attack_mode_e m);
    logic [BLOCK_W-1:0] r;
    case (m)
      MODE_LR_LOW:  r = 16'h0505;
      MODE_LR_ALL:  r = 16'h5555;
      MODE_FR_HIGH: r = 16'hAA00;
      MODE_FR_ALL:  r = 16'hCCCC;
      default:      r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] x_mask(input attack_mode_e m);
    logic [BLOCK_W-1:0] r;
    case (m)
      MODE_LR_LOW:  r = 16'h0B00;
      MODE_LR_ALL:  r = 16'h0090;
      MODE_FR_HIGH: r = 16'h0E00;
      MODE_FR_ALL:  r = 16'h00E0;
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/lckc_in_if.sv @@
// lckc_in_if: valid/ready channel carrying one plaintext/ciphertext pair
// depends on lckc_pkg
interface lckc_in_if
  import lckc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

@@ rtl/core/lckc_out_if.sv @@
// lckc_out_if: valid/ready channel carrying the winning candidate and bias
// depends on lckc_pkg
interface lckc_out_if
  import lckc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

@@ rtl/core/linear_cryptanalysis_key_counter_core.sv @@
// linear_cryptanalysis_key_counter_core: 256 counter cells updated in parallel per pair
// each taken pair is counted in the cells; a last pair then starts the scan for the result
// 1 pair per cycle when idle; a last pair blocks input for the scan, longer if a result waits
// the scan shifts zeros into the chain, so counters are clear again when it ends
// reset clears all counters, mode to 0 and expected_half to 5000
// depends on lckc_pkg, lckc_in_if, lckc_out_if, lckc_cell, lckc_scan
module linear_cryptanalysis_key_counter_core
  import lckc_pkg::*;
#(
  parameter int COUNT_WIDTH = lckc_pkg::COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lckc_in_if.snk           pair_i,
  lckc_out_if.src          result_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  attack_mode_e       mode_q;
  logic [CFG_W-1:0]   exp_half_q;
  scan_stat_t         stat;
  cell_ctrl_t         ctrl;
  logic               in_xfer;
  logic [BLOCK_W-1:0] raw;
  logic [COUNT_WIDTH-1:0] cnt [NUM_CANDIDATES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_LR_LOW;
      exp_half_q <= EXP_HALF_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ATTACK_MODE) begin
        mode_q <= attack_mode_e'(cfg_data_i[1:0]);
      end else begin
        exp_half_q <= cfg_data_i;
      end
    end
  end

  assign pair_i.ready = stat.idle;
  assign in_xfer      = pair_i.valid && pair_i.ready;

  always_comb begin
    raw          = last_round(mode_q) ? pair_i.data.plaintext : pair_i.data.ciphertext;
    ctrl.upd     = in_xfer;
    ctrl.shift   = stat.shift;
    ctrl.mode    = mode_q;
    ctrl.base    = last_round(mode_q) ? pair_i.data.ciphertext : pair_i.data.plaintext;
    ctrl.raw_par = ^(raw & x_mask(mode_q));
  end

  assign cnt[NUM_CANDIDATES] = '0;

  for (genvar g = 0; g < NUM_CANDIDATES; g++) begin : g_cell
    lckc_cell #(
      .CountW (COUNT_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cand_i     (CAND_W'(g)),
      .shift_in_i (cnt[g+1]),
      .count_o    (cnt[g])
    );
  end

  lckc_scan #(
    .CountW (COUNT_WIDTH)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (in_xfer && pair_i.data.last_pair),
    .head_count_i    (cnt[0]),
    .expected_half_i (exp_half_q),
    .out_ready_i     (result_o.ready),
    .stat_o          (stat),
    .out_valid_o     (result_o.valid),
    .out_data_o      (result_o.data)
  );

  a_no_take_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.shift |-> !pair_i.ready)
    else $error("pair taken while scanning");

  a_last_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && pair_i.data.last_pair) |=> stat.shift)
    else $error("last pair did not start the scan");

  a_cleared_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stat.idle && !stat.shift) |-> (cnt[0] == '0))
    else $error("counters not cleared after scan");

endmodule

@@ rtl/core/lckc_cell.sv @@
// lckc_cell: one candidate counter with its own parity evaluation
// shifts its count to the neighbor during the scan; depends on lckc_pkg
module lckc_cell
  import lckc_pkg::*;
#(
  parameter int CountW = COUNT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CAND_W-1:0] cand_i,
  input  logic [CountW-1:0] shift_in_i,
  output logic [CountW-1:0] count_o
);

  logic [CountW-1:0]  count_q, count_d;
  logic [BLOCK_W-1:0] u;
  logic               par;
  logic               hit;

  always_comb begin
    u   = substitute(ctrl_i.base ^ key_mask(ctrl_i.mode, cand_i), last_round(ctrl_i.mode));
    par = (^(u & u_mask(ctrl_i.mode))) ^ ctrl_i.raw_par;
    hit = ctrl_i.upd && !par && (count_q != {CountW{1'b1}});
    if (ctrl_i.shift) begin
      count_d = shift_in_i;
    end else if (hit) begin
      count_d = count_q + CountW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

@@ rtl/core/lckc_scan.sv @@
// lckc_scan: sequencer and max-bias comparator fed from the head of the cell chain
// holds the result register; depends on lckc_pkg
module lckc_scan
  import lckc_pkg::*;
#(
  parameter int CountW = COUNT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CountW-1:0] head_count_i,
  input  logic [CFG_W-1:0]  expected_half_i,
  input  logic              out_ready_i,
  output scan_stat_t        stat_o,
  output logic              out_valid_o,
  output out_item_t         out_data_o
);

  localparam int BiasW = (CountW > BIAS_W) ? CountW : BIAS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CAND_W-1:0] idx_q, idx_d;
  logic [CAND_W-1:0] best_q, best_d;
  logic [BiasW-1:0]  bias_q, bias_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;
  logic [BiasW-1:0]  cnt_x, eh_x, b;
  logic              out_free;

  always_comb begin
    cnt_x    = BiasW'(head_count_i);
    eh_x     = BiasW'(expected_half_i);
    b        = (cnt_x >= eh_x) ? cnt_x - eh_x : eh_x - cnt_x;
    out_free = !out_valid_q || out_ready_i;

    state_d     = state_q;
    idx_d       = idx_q;
    best_d      = best_q;
    bias_d      = bias_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if ((idx_q == '0) || (b >= bias_q)) begin
          best_d = idx_q;
          bias_d = b;
        end
        idx_d = idx_q + CAND_W'(1);
        if (idx_q == {CAND_W{1'b1}}) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_data_d.best_candidate = best_q;
          out_data_d.max_bias       = (bias_q > BiasW'({BIAS_W{1'b1}})) ?
                                      {BIAS_W{1'b1}} : bias_q[BIAS_W-1:0];
          state_d                   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    bias_q     <= bias_d;
    out_data_q <= out_data_d;
  end

  assign stat_o.idle  = (state_q == S_IDLE);
  assign stat_o.shift = (state_q == S_SCAN);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

endmodule

@@ tb/lckc_checker.sv @@
`timescale 1ns / 1ps
// lckc_checker: watches the pair and result channels and the register port, keeps its own
// copy of the 256 candidate counters and checks every result in order
// depends on lckc_pkg, lckc_in_if, lckc_out_if
module lckc_checker
  import lckc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  lckc_in_if               pair_i,
  lckc_out_if              result_i,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               pairs_o,
  output int               results_o
);

  localparam longint     COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 1;
  localparam longint     BIAS_MAX    = (64'd1 << BIAS_W) - 1;
  localparam int         MAX_REPORTS = 10;
  // forward s-box, entry i in nibble i
  localparam logic [63:0] SBOX_ENC   = 64'h7095_C6A3_8BF2_1D4E;

  logic [3:0]                sbox_dec [16];
  attack_mode_e              cur_mode;
  logic [CFG_W-1:0]          cur_half;
  longint                    cand_count [NUM_CANDIDATES];
  out_item_t                 best_results [$];
  logic                      hits_ok;
  logic [2+2*BLOCK_W-1:0]    hits_key;
  logic [NUM_CANDIDATES-1:0] hits;
  out_item_t                 want;
  longint                    bias_dev;
  longint                    best_dist;
  int                        best_j;
  int                        fails;

  initial begin
    for (int i = 0; i < 16; i++) sbox_dec[SBOX_ENC[4*i +: 4]] = 4'(i);
  end

  // one bit per candidate: set when the approximation parity is zero
  function automatic logic [NUM_CANDIDATES-1:0] zero_parity_hits(input attack_mode_e m,
                                                                 input logic [BLOCK_W-1:0] pt,
                                                                 input logic [BLOCK_W-1:0] ct);
    logic [NUM_CANDIDATES-1:0] r;
    logic [BLOCK_W-1:0]        base, raw, umask, xmask, kmask, v, u;
    logic [3:0]                lo, hi;
    logic                      decrypt;
    decrypt = (m == MODE_LR_LOW) || (m == MODE_LR_ALL);
    base    = decrypt ? ct : pt;
    raw     = decrypt ? pt : ct;
    case (m)
      MODE_LR_LOW:  begin umask = 16'h0505; xmask = 16'h0B00; end
      MODE_LR_ALL:  begin umask = 16'h5555; xmask = 16'h0090; end
      MODE_FR_HIGH: begin umask = 16'hAA00; xmask = 16'h0E00; end
      default:      begin umask = 16'hCCCC; xmask = 16'h00E0; end
    endcase
    for (int j = 0; j < NUM_CANDIDATES; j++) begin
      lo = j[3:0];
      hi = j[7:4];
      case (m)
        MODE_LR_LOW:  kmask = BLOCK_W'(lo) | (BLOCK_W'(hi) << 8);
        MODE_LR_ALL:  kmask = (BLOCK_W'(lo) << 4) | (BLOCK_W'(hi) << 12) | MODE1_FIXED;
        MODE_FR_HIGH: kmask = BLOCK_W'(lo) << 8;
        default:      kmask = BLOCK_W'(j[7:0]) | MODE3_FIXED;
      endcase
      v = base ^ kmask;
      for (int n = 0; n < 4; n++) begin
        u[4*n +: 4] = decrypt ? sbox_dec[v[4*n +: 4]] : SBOX_ENC[4*v[4*n +: 4] +: 4];
      end
      r[j] = ~((^(u & umask)) ^ (^(raw & xmask)));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = MODE_LR_LOW;
      cur_half = EXP_HALF_RST;
      foreach (cand_count[j]) cand_count[j] = 0;
      best_results.delete();
      hits_ok = 1'b0;
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      pairs_o      <= 0;
      results_o    <= 0;
    end else begin
      if (pair_i.valid && pair_i.ready) begin
        // repeated pairs reuse the previous hit vector
        if (!hits_ok || hits_key != {cur_mode, pair_i.data.plaintext, pair_i.data.ciphertext})
        begin
          hits     = zero_parity_hits(cur_mode, pair_i.data.plaintext, pair_i.data.ciphertext);
          hits_key = {cur_mode, pair_i.data.plaintext, pair_i.data.ciphertext};
          hits_ok  = 1'b1;
        end
        for (int j = 0; j < NUM_CANDIDATES; j++) begin
          if (hits[j] && cand_count[j] < COUNT_MAX) cand_count[j]++;
        end
        if (pair_i.data.last_pair) begin
          best_j    = 0;
          best_dist = 0;
          for (int j = 0; j < NUM_CANDIDATES; j++) begin
            bias_dev = (cand_count[j] >= cur_half) ? cand_count[j] - cur_half
                                                   : cur_half - cand_count[j];
            if (j == 0 || bias_dev >= best_dist) begin
              best_dist = bias_dev;
              best_j    = j;
            end
            cand_count[j] = 0;
          end
          want.best_candidate = CAND_W'(best_j);
          want.max_bias       = (best_dist > BIAS_MAX) ? BIAS_W'(BIAS_MAX) : BIAS_W'(best_dist);
          best_results.push_back(want);
        end
        pairs_o <= pairs_o + 1;
      end
      if (result_i.valid && result_i.ready) begin
        results_o <= results_o + 1;
        if (best_results.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: result transfer with none pending: candidate %0d bias %0d", $time,
                     result_i.data.best_candidate, result_i.data.max_bias);
          end
        end else begin
          want = best_results.pop_front();
          if (result_i.data.best_candidate !== want.best_candidate ||
              result_i.data.max_bias !== want.max_bias) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: result %0d wrong: expected candidate %0d bias %0d, got %0d bias %0d",
                       $time, results_o, want.best_candidate, want.max_bias,
                       result_i.data.best_candidate, result_i.data.max_bias);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK_MODE:   cur_mode = attack_mode_e'(cfg_data_i[1:0]);
          REG_EXPECTED_HALF: cur_half = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= best_results.size();
    end
  end

endmodule

@@ tb/tb_linear_cryptanalysis_key_counter_core.sv @@
`timescale 1ns / 1ps
// tb_linear_cryptanalysis_key_counter_core: drives pair runs, register writes and result stalls
// into the key counter core; lckc_checker does the prediction and comparison
// depends on lckc_pkg, lckc_in_if, lckc_out_if, lckc_checker and the core
module tb_linear_cryptanalysis_key_counter_core;
  import lckc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SCAN_WAIT    = NUM_CANDIDATES + 16;
  localparam int MAX_CYCLES   = 2_000_000;
  localparam int RANDOM_PAIRS = 1_530;
  localparam int HOLD_CYCLES  = 1_500;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int               snd_idle_pct;
  int               rcv_idle_pct;
  int               hold_req;
  int               hold_left;
  int               cycle_cnt;
  int               fail_count;
  int               pending;
  int               pair_count;
  int               result_count;

  lckc_in_if  pair_if ();
  lckc_out_if result_if ();

  linear_cryptanalysis_key_counter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (pair_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  lckc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair_if),
    .result_i     (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pairs_o      (pair_count),
    .results_o    (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < MAX_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("linear_cryptanalysis_key_counter_core: mismatch");
    $finish;
  end

  // result side, with an optional long hold-off
  initial begin
    result_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [BLOCK_W-1:0] rand_block();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return BLOCK_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_pair(input logic [BLOCK_W-1:0] pt, input logic [BLOCK_W-1:0] ct,
                           input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      pair_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    pair_if.valid                <= 1'b1;
    pair_if.data.plaintext       <= pt;
    pair_if.data.ciphertext      <= ct;
    pair_if.data.last_pair       <= last;
    do @(posedge clk_i); while (!pair_if.ready);
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_pair(rand_block(), rand_block(), i == len - 1);
  endtask

  // drop valid, drain pending results, then let any scan finish
  task automatic wait_idle();
    @(negedge clk_i);
    pair_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SCAN_WAIT) @(negedge clk_i);
  endtask

  task automatic mode_pair(input attack_mode_e m, input logic [CFG_W-1:0] half);
    write_reg(REG_ATTACK_MODE, CFG_W'(m));
    write_reg(REG_EXPECTED_HALF, half);
    send_pair(16'h1234, 16'hABCD, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    wait_idle();
  endtask

  initial begin
    int  sent;
    int  len;
    int  half;
    bit  fresh;
    cfg_we        = 1'b0;
    cfg_idx       = REG_ATTACK_MODE;
    cfg_data      = '0;
    pair_if.valid = 1'b0;
    pair_if.data  = '0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    hold_req      = 0;
    rst_ni        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-pair runs and a three-pair run under reset settings, where ties are everywhere
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'hA5A5, 16'h5A5A, 1'b1);
    wait_idle();
    mode_pair(MODE_LR_LOW, 16'h0000);
    mode_pair(MODE_LR_ALL, 16'hFFFF);
    mode_pair(MODE_FR_HIGH, 16'h0001);
    mode_pair(MODE_FR_ALL, EXP_HALF_RST);

    // settings changed in the middle of a run keep the counters
    write_reg(REG_ATTACK_MODE, CFG_W'(MODE_LR_ALL));
    write_reg(REG_EXPECTED_HALF, 16'h0001);
    send_pair(16'h0F0F, 16'hF0F0, 1'b0);
    send_pair(16'h3C3C, 16'hC3C3, 1'b0);
    wait_idle();
    write_reg(REG_ATTACK_MODE, CFG_W'(MODE_FR_HIGH));
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    wait_idle();
    write_reg(REG_EXPECTED_HALF, 16'h0002);
    send_pair(16'h8001, 16'h7FFE, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 11; rcv_idle_pct = 81; end
        1:       begin snd_idle_pct = 81; rcv_idle_pct = 11; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      sent  = 0;
      fresh = 1'b1;
      if (ph == 1) begin
        // results are held back while pairs keep coming, so the input stalls
        wait_idle();
        hold_req = HOLD_CYCLES;
        repeat (3) send_run(8);
        sent = 24;
      end
      while (sent < RANDOM_PAIRS / 3) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(200, 80) : $urandom_range(30, 1);
        if (fresh || $urandom_range(2) == 0) begin
          case ($urandom_range(5))
            0:       half = 0;
            1:       half = 16'hFFFF;
            2:       half = len / 2;
            3:       half = $urandom_range(len, 0);
            4:       half = $urandom_range(16'hFFFF, 0);
            default: half = EXP_HALF_RST;
          endcase
          wait_idle();
          write_reg(REG_ATTACK_MODE, CFG_W'(attack_mode_e'($urandom_range(3))));
          write_reg(REG_EXPECTED_HALF, CFG_W'(half));
          fresh = 1'b0;
        end
        send_run(len);
        sent += len;
      end
    end

    wait_idle();
    $display("covered %0d pair transfers and %0d checked results over all four attack modes",
             pair_count, result_count);
    $display("including a %0d-cycle result hold-off that stalled the pair input",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_cryptanalysis_key_counter_core: match");
    end else begin
      $display("linear_cryptanalysis_key_counter_core: mismatch");
    end
    $finish;
  end

endmodule
